// ===== design/dria_pkg.sv =====
// Shared types, constants and helpers for the reward-inaction learning automaton.
`default_nettype none

package dria_pkg;

	// Table geometry and probability scale.
	localparam int NUM_ACTIONS = 6;
	localparam int PROB_SCALE  = 2400;
	localparam int IDX_W       = (NUM_ACTIONS > 1) ? $clog2(NUM_ACTIONS) : 1;
	localparam int PROB_W      = 12;
	localparam int ACC_W       = PROB_W + IDX_W;
	localparam logic [IDX_W-1:0]  LAST_IDX   = IDX_W'(NUM_ACTIONS - 1);
	localparam logic [PROB_W-1:0] PROB_RESET = PROB_W'(PROB_SCALE / NUM_ACTIONS);

	// Field widths of the items.
	localparam int DRAW_W  = 12;
	localparam int POS_W   = 3;
	localparam int ACT_W   = 3;
	localparam int STEP_W  = 9;
	localparam int LEVEL_W = 12;
	localparam int TOT_W   = 32;
	localparam int COST_W  = 5;

	// Configuration port.
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 12;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_UNITS     = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CONVERGE_LEVEL = 1'd1;
	localparam logic [STEP_W-1:0]    STEP_RESET         = 9'd6;
	localparam logic [LEVEL_W-1:0]   LEVEL_RESET        = 12'd2376;

	typedef struct packed {
		logic [DRAW_W-1:0] draw;
		logic [POS_W-1:0]  target_pos;
		logic [POS_W-1:0]  prior_pos;
	} dria_in_t;

	typedef struct packed {
		logic [ACT_W-1:0]  chosen_action;
		logic              rewarded;
		logic              converged_now;
		logic [PROB_W-1:0] chosen_prob;
		logic [TOT_W-1:0]  inaction_sum;
		logic [TOT_W-1:0]  action_sum;
	} dria_out_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic sel_step;
		logic score;
		logic upd_step;
		logic apply;
		logic finish;
	} dria_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic sel_done;
		logic reward;
		logic upd_last;
		logic out_busy;
	} dria_sts_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SELECT,
		S_SCORE,
		S_UPDATE,
		S_APPLY,
		S_FINISH
	} dria_state_t;

	function automatic logic [COST_W-1:0] absdiff(input logic [COST_W-1:0] a,
			input logic [COST_W-1:0] b);
		return (a > b) ? (a - b) : (b - a);
	endfunction

endpackage

`default_nettype wire

// ===== design/dria_ctrl.sv =====
// Controller state machine that sequences selection, scoring and table update.
`default_nettype none

module dria_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire dria_pkg::dria_sts_t sts,
	output dria_pkg::dria_cmd_t     cmd,
	output logic                    in_stall
);
	import dria_pkg::*;

	dria_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_stall = 1'b1;
		unique case (state_q)
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = S_SELECT;
				end
			end
			S_SELECT: begin
				cmd.sel_step = 1'b1;
				if (sts.sel_done) begin
					state_d = S_SCORE;
				end
			end
			S_SCORE: begin
				cmd.score = 1'b1;
				state_d   = sts.reward ? S_UPDATE : S_FINISH;
			end
			S_UPDATE: begin
				cmd.upd_step = 1'b1;
				if (sts.upd_last) begin
					state_d = S_APPLY;
				end
			end
			S_APPLY: begin
				cmd.apply = 1'b1;
				state_d   = S_FINISH;
			end
			S_FINISH: begin
				if (!sts.out_busy) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== design/dria_dp.sv =====
// Datapath: probability table, cost totals, configuration and output register.
`default_nettype none

module dria_dp (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire dria_pkg::dria_in_t             in_data,
	input  wire logic                           cfg_we,
	input  wire logic [dria_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [dria_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire dria_pkg::dria_cmd_t            cmd,
	output dria_pkg::dria_sts_t                 sts,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output dria_pkg::dria_out_t                 out_data
);
	import dria_pkg::*;

	logic [PROB_W-1:0]  prob_q [NUM_ACTIONS];
	logic [TOT_W-1:0]   inaction_tot_q, action_tot_q;
	logic               seen_q;
	logic [STEP_W-1:0]  step_q;
	logic [LEVEL_W-1:0] level_q;
	logic               out_valid_q;
	logic [IDX_W-1:0]   idx_q;

	dria_in_t           item_q;
	logic [ACC_W-1:0]   acc_q;
	logic [IDX_W-1:0]   chosen_q;
	logic [PROB_W-1:0]  chosen_val_q;
	logic [PROB_W-1:0]  moved_q;
	logic               reward_q;
	logic               conv_q;
	dria_out_t          out_q;

	logic [PROB_W-1:0]  rd;
	logic [ACC_W-1:0]   acc_sum;
	logic               hit;
	logic [COST_W-1:0]  cost_idle, cost_act;
	logic [TOT_W:0]     inaction_add, action_add;
	logic               take;
	logic [PROB_W-1:0]  new_prob;

	assign rd       = prob_q[idx_q];
	assign acc_sum  = acc_q + ACC_W'(rd);
	assign hit      = acc_sum > ACC_W'(item_q.draw);

	assign cost_idle = absdiff(COST_W'(item_q.prior_pos), COST_W'(item_q.target_pos));
	assign cost_act  = absdiff(COST_W'(chosen_q), COST_W'(item_q.target_pos))
		+ (absdiff(COST_W'(item_q.prior_pos), COST_W'(chosen_q)) >> 1);

	assign inaction_add = {1'b0, inaction_tot_q} + (TOT_W + 1)'(cost_idle);
	assign action_add   = {1'b0, action_tot_q} + (TOT_W + 1)'(cost_act);

	assign take     = (idx_q != chosen_q) && (rd > PROB_W'(step_q));
	assign new_prob = chosen_val_q + moved_q;

	assign sts.sel_done = hit || (idx_q == LAST_IDX);
	assign sts.reward   = cost_idle > cost_act;
	assign sts.upd_last = idx_q == LAST_IDX;
	assign sts.out_busy = out_valid_q && out_stall;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// State that the reset defines.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_ACTIONS; k++) begin
				prob_q[k] <= PROB_RESET;
			end
			inaction_tot_q <= '0;
			action_tot_q   <= '0;
			seen_q         <= 1'b0;
			step_q         <= STEP_RESET;
			level_q        <= LEVEL_RESET;
			out_valid_q    <= 1'b0;
			idx_q          <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_STEP_UNITS:     step_q  <= cfg_data[STEP_W-1:0];
					CFG_CONVERGE_LEVEL: level_q <= cfg_data[LEVEL_W-1:0];
					default: ;
				endcase
			end
			if (cmd.load || cmd.score) begin
				idx_q <= '0;
			end else if ((cmd.sel_step && !sts.sel_done) || (cmd.upd_step && !sts.upd_last)) begin
				idx_q <= idx_q + 1'b1;
			end
			if (cmd.score) begin
				inaction_tot_q <= inaction_add[TOT_W] ? '1 : inaction_add[TOT_W-1:0];
				action_tot_q   <= action_add[TOT_W] ? '1 : action_add[TOT_W-1:0];
			end
			if (cmd.upd_step && take) begin
				prob_q[idx_q] <= rd - PROB_W'(step_q);
			end
			if (cmd.apply) begin
				prob_q[chosen_q] <= new_prob;
				if (!seen_q && (new_prob > level_q)) begin
					seen_q <= 1'b1;
				end
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working registers of the item in flight and the result register.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			item_q <= in_data;
			acc_q  <= '0;
			conv_q <= 1'b0;
		end
		if (cmd.sel_step) begin
			acc_q <= acc_sum;
			if (sts.sel_done) begin
				chosen_q     <= idx_q;
				chosen_val_q <= rd;
			end
		end
		if (cmd.score) begin
			reward_q <= sts.reward;
			moved_q  <= '0;
		end
		if (cmd.upd_step && take) begin
			moved_q <= moved_q + PROB_W'(step_q);
		end
		if (cmd.apply) begin
			chosen_val_q <= new_prob;
			conv_q       <= !seen_q && (new_prob > level_q);
		end
		if (cmd.finish) begin
			out_q.chosen_action <= ACT_W'(chosen_q);
			out_q.rewarded      <= reward_q;
			out_q.converged_now <= conv_q;
			out_q.chosen_prob   <= chosen_val_q;
			out_q.inaction_sum  <= inaction_tot_q;
			out_q.action_sum    <= action_tot_q;
		end
	end

endmodule

`default_nettype wire

// ===== design/discretized_reward_inaction_automaton.sv =====
// Top level of the discretized linear reward-inaction learning automaton.
// Sequence: once an item is taken, selection reads entries until one is chosen, then the item is
// scored; on reward an update sweep and a credit write follow, then the result is loaded for output.
// Only one item is in flight at a time; a result still held by the receiver delays the
// next output load, and with it the next item, until that result is taken.
// Asynchronous reset: table entries 400, totals and flag cleared, step 6, level 2376.
`default_nettype none

module discretized_reward_inaction_automaton (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire dria_pkg::dria_in_t              in_data,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output dria_pkg::dria_out_t                  out_data,
	input  wire logic                            cfg_we,
	input  wire logic [dria_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [dria_pkg::CFG_DATA_W-1:0] cfg_data
);
	import dria_pkg::*;

	// The controller walks the states; the datapath owns every stored value.
	// Selection reads one table entry per cycle and keeps a running sum, stopping at the
	// first entry whose cumulative total exceeds the draw, or at the last entry. The chosen
	// entry's value is captured then, so the update sweep never needs a second read port.
	// The update sweep takes step_units from each other entry that stays above zero and the
	// chosen entry receives the whole amount in a single write afterwards.
	dria_cmd_t cmd;
	dria_sts_t sts;

	dria_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.sts      (sts),
		.cmd      (cmd),
		.in_stall (in_stall)
	);

	// The output register lets a finished result wait while the datapath is released.
	dria_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire

// ===== design/dria_checker.sv =====
// Port-level checker for the automaton, bound to the top level.
`default_nettype none

module dria_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            in_valid,
	input wire logic                            in_stall,
	input wire logic                            out_valid,
	input wire logic                            out_stall,
	input wire dria_pkg::dria_out_t             out_data
);
	import dria_pkg::*;

	// A result that waits must hold still.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// Only one item is worked on at a time.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second item taken while one is in flight");

	// Convergence can only be reported on a rewarded item.
	a_conv_needs_reward: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.rewarded |-> !out_data.converged_now)
		else $error("convergence reported without reward");

	// The chosen action always names a table entry.
	a_action_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.chosen_action < ACT_W'(NUM_ACTIONS)))
		else $error("chosen action out of range");

endmodule

bind discretized_reward_inaction_automaton dria_checker u_dria_checker (.*);

`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for the discretized reward-inaction learning automaton.
`timescale 1ns / 1ps

module testbench;
	import dria_pkg::*;

	// Predicts each round of the automaton from the inputs alone and checks the
	// rounds that come out of the block against those predictions, in order.
	class round_scoreboard;
		logic [PROB_W-1:0]  prob [NUM_ACTIONS];
		logic [TOT_W-1:0]   idle_total;
		logic [TOT_W-1:0]   act_total;
		bit                 conv_seen;
		logic [STEP_W-1:0]  step;
		logic [LEVEL_W-1:0] level;
		dria_out_t          awaited_rounds [$];
		int                 mismatches;
		int                 rounds_checked;

		function new();
			foreach (prob[k])
				prob[k] = PROB_RESET;
			idle_total = '0;
			act_total = '0;
			conv_seen = 1'b0;
			step = STEP_RESET;
			level = LEVEL_RESET;
			mismatches = 0;
			rounds_checked = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				CFG_STEP_UNITS: step = val[STEP_W-1:0];
				CFG_CONVERGE_LEVEL: level = val[LEVEL_W-1:0];
				default: ;
			endcase
		endfunction

		function int gap(int a, int b);
			return (a > b) ? a - b : b - a;
		endfunction

		function logic [TOT_W-1:0] add_sat(logic [TOT_W-1:0] tot, int cost);
			logic [TOT_W:0] s;
			s = {1'b0, tot} + (TOT_W+1)'(cost);
			return s[TOT_W] ? '1 : s[TOT_W-1:0];
		endfunction

		// One round: pick an action from the cumulative table, score it, and on a
		// reward pull one step from every other entry that can afford it.
		function dria_out_t predict_round(dria_in_t item);
			dria_out_t r;
			int run_sum;
			int pick;
			int prior;
			int target;
			int idle_cost;
			int act_cost;
			int moved;
			bit found;
			bit reward;
			bit conv;
			run_sum = 0;
			pick = NUM_ACTIONS - 1;
			found = 1'b0;
			for (int k = 0; k < NUM_ACTIONS; k++) begin
				run_sum += int'(prob[k]);
				if (!found && run_sum > int'(item.draw)) begin
					pick = k;
					found = 1'b1;
				end
			end
			prior = int'(item.prior_pos);
			target = int'(item.target_pos);
			idle_cost = gap(prior, target);
			act_cost = gap(pick, target) + gap(prior, pick) / 2;
			idle_total = add_sat(idle_total, idle_cost);
			act_total = add_sat(act_total, act_cost);
			reward = idle_cost > act_cost;
			conv = 1'b0;
			if (reward) begin
				moved = 0;
				for (int k = 0; k < NUM_ACTIONS; k++) begin
					if (k != pick && prob[k] > step) begin
						prob[k] = prob[k] - step;
						moved += int'(step);
					end
				end
				prob[pick] = prob[pick] + PROB_W'(moved);
				if (!conv_seen && prob[pick] > level) begin
					conv_seen = 1'b1;
					conv = 1'b1;
				end
			end
			r.chosen_action = ACT_W'(pick);
			r.rewarded = reward;
			r.converged_now = conv;
			r.chosen_prob = prob[pick];
			r.inaction_sum = idle_total;
			r.action_sum = act_total;
			return r;
		endfunction

		function void note_item(dria_in_t item);
			awaited_rounds.push_back(predict_round(item));
		endfunction

		function void check_result(dria_out_t got);
			dria_out_t want;
			bit bad;
			rounds_checked++;
			if (awaited_rounds.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("round %0d: result arrived with nothing awaited: act=%0d rew=%0b",
						rounds_checked, got.chosen_action, got.rewarded);
				return;
			end
			want = awaited_rounds.pop_front();
			bad = (got.chosen_action !== want.chosen_action)
				|| (got.rewarded !== want.rewarded)
				|| (got.converged_now !== want.converged_now)
				|| (got.chosen_prob !== want.chosen_prob)
				|| (got.inaction_sum !== want.inaction_sum)
				|| (got.action_sum !== want.action_sum);
			if (bad) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("round %0d expected: act=%0d rew=%0b conv=%0b prob=%0d idle=%0d act_sum=%0d",
						rounds_checked, want.chosen_action, want.rewarded, want.converged_now,
						want.chosen_prob, want.inaction_sum, want.action_sum);
					$display("round %0d actual:   act=%0d rew=%0b conv=%0b prob=%0d idle=%0d act_sum=%0d",
						rounds_checked, got.chosen_action, got.rewarded, got.converged_now,
						got.chosen_prob, got.inaction_sum, got.action_sum);
				end
			end
		endfunction

		function int pending();
			return awaited_rounds.size();
		endfunction
	endclass

	// Clock, reset and every input of the block start at known values.
	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	dria_in_t              in_data = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	dria_out_t             out_data;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	round_scoreboard board = new();

	// Idle rates in percent for the sender and the receiver. Setting both to
	// zero gives a stretch of back-to-back traffic.
	int in_idle_pct = 21;
	int out_idle_pct = 21;

	// The main process asks for a long receiver hold-off by bumping the grant
	// count; the receiver notices the change and counts the stretch itself.
	int hold_grants = 0;
	int hold_served = 0;
	int hold_left = 0;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	discretized_reward_inaction_automaton u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Receiver. Values read right after the edge are the ones the block saw at
	// that edge, since every update lands later in the time step. A result is
	// taken when out_valid was high and our own stall was low.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_result(out_data);
		if (hold_grants != hold_served) begin
			hold_served <= hold_grants;
			hold_left <= 300;
			out_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99, 0) < out_idle_pct);
		end
	end

	function automatic dria_in_t make_round(int draw, int target, int prior);
		dria_in_t item;
		item.draw = DRAW_W'(draw);
		item.target_pos = POS_W'(target);
		item.prior_pos = POS_W'(prior);
		return item;
	endfunction

	// Most random rounds stay in range and lean toward one favored target so
	// that the table actually concentrates; the rest are full-width noise that
	// covers draws past the scale and positions six and seven.
	function automatic dria_in_t random_round(int favored);
		int target;
		if ($urandom_range(99, 0) < 85) begin
			target = ($urandom_range(99, 0) < 60) ? favored : $urandom_range(NUM_ACTIONS - 1, 0);
			return make_round($urandom_range(PROB_SCALE - 1, 0), target,
				$urandom_range(NUM_ACTIONS - 1, 0));
		end
		return make_round($urandom_range(4095, 0), $urandom_range(7, 0), $urandom_range(7, 0));
	endfunction

	// Offers one item and returns at the edge where it was taken. Valid stays
	// high on return; the next call either lowers it for an idle gap or puts the
	// next item straight behind this one, so valid gets one assignment per step.
	task automatic send_item(input dria_in_t item);
		if ($urandom_range(99, 0) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99, 0) < in_idle_pct)
				@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= item;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		board.note_item(item);
	endtask

	task automatic run_random(input int count, input int favored);
		repeat (count)
			send_item(random_round(favored));
	endtask

	// Stops offering and waits until every awaited round has come back, then
	// lets the block settle for longer than its worst-case latency.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0)
			@(posedge clk);
		repeat (20)
			@(posedge clk);
	endtask

	// A write takes one edge; the extra edge keeps back-to-back writes from
	// assigning the enable twice in one step.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.set_reg(idx, val);
		@(posedge clk);
	endtask

	initial begin : stimulus
		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings. Directed rounds cover the draw extremes, a draw at
		// the scale and past it (no cumulative sum exceeds it, so the last
		// action wins), out-of-range positions six and seven, and rounds that
		// reward as well as ones that penalize.
		send_item(make_round(0, 0, 5));
		send_item(make_round(399, 0, 0));
		send_item(make_round(400, 5, 0));
		send_item(make_round(2399, 5, 5));
		send_item(make_round(2400, 0, 5));
		send_item(make_round(4095, 7, 0));
		send_item(make_round(12'hAAA, 6, 7));
		send_item(make_round(12'h555, 7, 6));
		send_item(make_round(0, 7, 7));
		send_item(make_round(1200, 2, 5));
		send_item(make_round(800, 3, 0));
		send_item(make_round(1999, 4, 1));
		send_item(make_round(2000, 1, 4));
		send_item(make_round(0, 6, 0));
		send_item(make_round(2399, 0, 7));
		send_item(make_round(1600, 7, 2));
		run_random(220, 0);
		drain();

		// Largest legal step and the top of the probability scale as level.
		write_reg(CFG_STEP_UNITS, 12'd400);
		write_reg(CFG_CONVERGE_LEVEL, 12'd2400);
		run_random(200, 5);
		drain();

		// Smallest legal step with every level bit set, run with no idling on
		// either side.
		write_reg(CFG_STEP_UNITS, 12'd1);
		write_reg(CFG_CONVERGE_LEVEL, 12'hFFF);
		in_idle_pct = 0;
		out_idle_pct = 0;
		run_random(260, 2);
		drain();
		in_idle_pct = 21;
		out_idle_pct = 21;

		// A zero step still reports rewards but leaves the table alone.
		write_reg(CFG_STEP_UNITS, 12'd0);
		send_item(make_round(0, 0, 5));
		send_item(make_round(2399, 5, 0));
		send_item(make_round(1200, 3, 0));
		run_random(150, 3);
		drain();

		// Upper data bits land outside the 9-bit step and are dropped, leaving
		// the widest step the register holds.
		write_reg(CFG_STEP_UNITS, 12'hFFF);
		write_reg(CFG_CONVERGE_LEVEL, 12'h800);
		run_random(200, 1);
		drain();

		// Level zero makes the first rewarded round raise the convergence flag
		// if nothing has yet. The receiver also holds off for a long stretch
		// while items keep coming, so the block backs up and stalls its input.
		write_reg(CFG_STEP_UNITS, 12'hE06);
		write_reg(CFG_CONVERGE_LEVEL, 12'd0);
		hold_grants++;
		run_random(300, 4);
		drain();

		write_reg(CFG_STEP_UNITS, 12'd37);
		write_reg(CFG_CONVERGE_LEVEL, 12'd1200);
		run_random(470, 0);
		drain();

		if (board.mismatches == 0 && board.pending() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Far beyond the slowest correct run, including the long hold-off.
	initial begin : watchdog
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
